// File: rtl/modbus_rtu_input_register_reply_check_macros.svh
// Assertion macros shared by the RTL of the reply checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MODBUS_RTU_INPUT_REGISTER_REPLY_CHECK_MACROS_SVH
`define MODBUS_RTU_INPUT_REGISTER_REPLY_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRIRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRIRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mrirc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrirc_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_WR   = 3'b100
  } state_t;

  // Reply status codes.
  typedef enum logic [1:0] {
    STS_GOOD    = 2'd0,
    STS_TIMEOUT = 2'd1,
    STS_BAD_LEN = 2'd2,
    STS_BAD_CRC = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_CHANNEL_COUNT  = 1'b1;

  // Input beat kinds carried on tuser.
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam int          MIN_REPLY_LEN   = 5;
  localparam int          MAX_REPORT      = 4;
  localparam int          OUT_DATA_W      = 120;

  // One byte of the reflected CRC-16, least significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mrirc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module mrirc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire                                        clk,
  input  wire                                        wr_en,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire [WIDTH-1:0]                            wr_data,
  input  wire                                        rd_en,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/modbus_rtu_input_register_reply_check.sv
// Modbus RTU read-input-registers reply checker. Reply bytes enter as input
// beats with in_tuser low; a beat with in_tuser high closes the reply window.
// Byte beats are taken one per clock outside a sweep: the CRC-16 (reflected
// poly 0xA001, init 0xFFFF) is folded in one byte per cycle and data words
// are staged in a small RAM. Only the first RX_LIMIT bytes of a window count.
// On close the header, length and CRC are judged in that cycle, the counters
// and online flag are updated, and a sweep then walks the effective channels
// (channel_count held to 1..MAX_CHANNELS): each channel has a read state for
// the staged and snapshot RAMs and then a write state that writes the snapshot
// back (taking the staged word when a good reply updated it). The first
// min(effective count, 4) channels each produce one output beat, tlast on the
// final one. A close therefore keeps in_tready low until the sweep is done,
// longer while the output is stalled; the snapshot RAM read/write turnaround
// is why each channel needs both states. Snapshot entries read as zero until
// first written (per-entry valid flags), so no clearing pass follows reset.
// Configuration may only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_input_register_reply_check_macros.svh"

module modbus_rtu_input_register_reply_check #(
  parameter int MAX_CHANNELS = 4,
  parameter int RX_LIMIT     = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // Configuration write port.
  input  wire         cfg_we,
  input  wire         cfg_addr,
  input  wire  [7:0]  cfg_data,
  // Input stream.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire         in_tuser,   // [0] action
  // Result stream.
  output logic        out_tvalid,
  input  wire         out_tready,
  // [1:0] status, [2] online, [4:3] channel_index, [20:5] channel_value,
  // [23:21] channels_updated, [55:24] crc_error_count,
  // [87:56] timeout_total, [119:88] frame_count
  output logic [mrirc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic         out_tlast
);

  // Address width of the per-channel RAMs.
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // Byte position width: must hold RX_LIMIT itself.
  localparam int PW = $clog2(RX_LIMIT + 1);
  // Width for position arithmetic: covers 5 + 255 and RX_LIMIT.
  localparam int EW = 10;

  // Control state.
  mrirc_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]     bpos_r, bpos_nxt;
  logic              hdr_ok_r, hdr_ok_nxt;
  logic [7:0]        rbc_r, rbc_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       crc_frm_r, crc_frm_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              online_r, online_nxt;
  logic [31:0]       crc_err_cnt_r, crc_err_cnt_nxt;
  logic [31:0]       tmo_cnt_r, tmo_cnt_nxt;
  logic [31:0]       good_cnt_r, good_cnt_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [2:0]        upd_r, upd_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [MAX_CHANNELS-1:0] snap_vld_r, snap_vld_nxt;
  logic [7:0]        dev_addr_r, dev_addr_nxt;
  logic [2:0]        chan_cnt_r, chan_cnt_nxt;
  logic              out_vld_r, out_vld_nxt;

  // Output payload.
  logic [mrirc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  // RAM ports.
  logic              stg_we;
  logic [AW-1:0]     stg_waddr;
  logic [15:0]       stg_wdata;
  logic [15:0]       stg_rdata;
  logic              snap_we;
  logic [15:0]       snap_wdata;
  logic [15:0]       snap_rdata;
  logic              ram_re;
  logic [AW-1:0]     sweep_addr;

  // Derived values.
  logic [2:0]        eff;
  logic [2:0]        report;
  logic              in_acc;
  logic [EW-1:0]     pos;
  logic [EW-1:0]     crc_end;
  logic [EW-1:0]     data_off;
  logic [EW-1:0]     need_len;
  logic [7:0]        half_bc;
  logic              emit;
  logic              can_go;
  logic [15:0]       chan_val;

  assign in_tready  = (state_r == mrirc_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign sweep_addr = AW'(idx_r);

  // Effective channel count and the number of results per close.
  always_comb begin
    if (chan_cnt_r == 3'd0) begin
      eff = 3'd1;
    end else if (int'(chan_cnt_r) > MAX_CHANNELS) begin
      eff = 3'(MAX_CHANNELS);
    end else begin
      eff = chan_cnt_r;
    end
    report = (int'(eff) > mrirc_pkg::MAX_REPORT) ? 3'(mrirc_pkg::MAX_REPORT) : eff;
  end

  assign pos       = EW'(bpos_r);
  assign crc_end   = (pos < EW'(3)) ? EW'(3) : (EW'(3) + EW'(rbc_r));
  assign data_off  = pos - EW'(3);
  assign need_len  = EW'(5) + EW'(rbc_r);
  assign half_bc   = rbc_r >> 1;
  assign emit      = (idx_r < report);
  assign can_go    = !emit || !out_vld_r || out_tready;
  assign chan_val  = (idx_r < upd_r) ? stg_rdata :
                     (snap_vld_r[sweep_addr] ? snap_rdata : 16'h0000);

  always_comb begin
    state_nxt       = state_r;
    bpos_nxt        = bpos_r;
    hdr_ok_nxt      = hdr_ok_r;
    rbc_nxt         = rbc_r;
    crc_nxt         = crc_r;
    crc_frm_nxt     = crc_frm_r;
    hold_nxt        = hold_r;
    online_nxt      = online_r;
    crc_err_cnt_nxt = crc_err_cnt_r;
    tmo_cnt_nxt     = tmo_cnt_r;
    good_cnt_nxt    = good_cnt_r;
    status_nxt      = status_r;
    upd_nxt         = upd_r;
    idx_nxt         = idx_r;
    snap_vld_nxt    = snap_vld_r;
    dev_addr_nxt    = dev_addr_r;
    chan_cnt_nxt    = chan_cnt_r;
    out_vld_nxt     = out_vld_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    stg_we          = 1'b0;
    stg_waddr       = data_off[AW:1];
    stg_wdata       = {hold_r, in_tdata};
    snap_we         = 1'b0;
    snap_wdata      = chan_val;
    ram_re          = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        mrirc_pkg::REG_DEVICE_ADDRESS: dev_addr_nxt = cfg_data;
        mrirc_pkg::REG_CHANNEL_COUNT:  chan_cnt_nxt = cfg_data[2:0];
        default: ;
      endcase
    end

    unique case (state_r)
      mrirc_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == mrirc_pkg::ACT_BYTE)) begin
          if (int'(bpos_r) < RX_LIMIT) begin
            // Header bytes.
            if (pos == EW'(0)) begin
              hdr_ok_nxt = (in_tdata == dev_addr_r);
            end else if (pos == EW'(1)) begin
              hdr_ok_nxt = hdr_ok_r && (in_tdata == mrirc_pkg::FUNC_READ_INPUT);
            end else if (pos == EW'(2)) begin
              rbc_nxt = in_tdata;
            end
            // CRC-covered bytes, then the two CRC bytes, low first.
            if (pos < crc_end) begin
              crc_nxt = mrirc_pkg::crc16_byte(crc_r, in_tdata);
              if (pos >= EW'(3)) begin
                if (!data_off[0]) begin
                  hold_nxt = in_tdata;
                end else if (int'(data_off >> 1) < MAX_CHANNELS) begin
                  stg_we = 1'b1;
                end
              end
            end else if (pos == crc_end) begin
              crc_frm_nxt[7:0] = in_tdata;
            end else if (pos == crc_end + EW'(1)) begin
              crc_frm_nxt[15:8] = in_tdata;
            end
            bpos_nxt = bpos_r + PW'(1);
          end
        end else if (in_acc && (in_tuser == mrirc_pkg::ACT_CLOSE)) begin
          upd_nxt = 3'd0;
          if ((int'(bpos_r) < mrirc_pkg::MIN_REPLY_LEN) || !hdr_ok_r) begin
            status_nxt  = mrirc_pkg::STS_TIMEOUT;
            online_nxt  = 1'b0;
            tmo_cnt_nxt = tmo_cnt_r + 32'd1;
          end else if ((rbc_r == 8'd0) || (rbc_r > {4'd0, eff, 1'b0}) ||
                       (need_len > pos)) begin
            status_nxt      = mrirc_pkg::STS_BAD_LEN;
            crc_err_cnt_nxt = crc_err_cnt_r + 32'd1;
          end else if (crc_r != crc_frm_r) begin
            status_nxt      = mrirc_pkg::STS_BAD_CRC;
            crc_err_cnt_nxt = crc_err_cnt_r + 32'd1;
          end else begin
            status_nxt   = mrirc_pkg::STS_GOOD;
            upd_nxt      = (half_bc > {5'd0, eff}) ? eff : half_bc[2:0];
            online_nxt   = 1'b1;
            good_cnt_nxt = good_cnt_r + 32'd1;
          end
          // Reset the per-reply window.
          bpos_nxt    = '0;
          hdr_ok_nxt  = 1'b0;
          rbc_nxt     = 8'd0;
          crc_nxt     = mrirc_pkg::CRC_INIT;
          crc_frm_nxt = 16'h0000;
          hold_nxt    = 8'd0;
          idx_nxt     = 3'd0;
          state_nxt   = mrirc_pkg::ST_RD;
        end
      end

      mrirc_pkg::ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = mrirc_pkg::ST_WR;
      end

      mrirc_pkg::ST_WR: begin
        if (can_go) begin
          snap_we                  = 1'b1;
          snap_vld_nxt[sweep_addr] = 1'b1;
          if (emit) begin
            out_vld_nxt  = 1'b1;
            out_last_nxt = ((idx_r + 3'd1) == report);
            out_data_nxt = {good_cnt_r, tmo_cnt_r, crc_err_cnt_r, upd_r,
                            chan_val, idx_r[1:0], online_r, status_r};
          end
          if ((idx_r + 3'd1) == eff) begin
            state_nxt = mrirc_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = mrirc_pkg::ST_RD;
          end
        end
      end

      default: state_nxt = mrirc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mrirc_pkg::ST_IDLE;
      bpos_r        <= '0;
      hdr_ok_r      <= 1'b0;
      rbc_r         <= 8'd0;
      crc_r         <= mrirc_pkg::CRC_INIT;
      crc_frm_r     <= 16'h0000;
      hold_r        <= 8'd0;
      online_r      <= 1'b0;
      crc_err_cnt_r <= 32'd0;
      tmo_cnt_r     <= 32'd0;
      good_cnt_r    <= 32'd0;
      status_r      <= mrirc_pkg::STS_GOOD;
      upd_r         <= 3'd0;
      idx_r         <= 3'd0;
      snap_vld_r    <= '0;
      dev_addr_r    <= 8'd1;
      chan_cnt_r    <= 3'd4;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      bpos_r        <= bpos_nxt;
      hdr_ok_r      <= hdr_ok_nxt;
      rbc_r         <= rbc_nxt;
      crc_r         <= crc_nxt;
      crc_frm_r     <= crc_frm_nxt;
      hold_r        <= hold_nxt;
      online_r      <= online_nxt;
      crc_err_cnt_r <= crc_err_cnt_nxt;
      tmo_cnt_r     <= tmo_cnt_nxt;
      good_cnt_r    <= good_cnt_nxt;
      status_r      <= status_nxt;
      upd_r         <= upd_nxt;
      idx_r         <= idx_nxt;
      snap_vld_r    <= snap_vld_nxt;
      dev_addr_r    <= dev_addr_nxt;
      chan_cnt_r    <= chan_cnt_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Staged words of the reply in progress.
  mrirc_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CHANNELS)
  ) u_stage_ram (
    .clk     (clk),
    .wr_en   (stg_we),
    .wr_addr (stg_waddr),
    .wr_data (stg_wdata),
    .rd_en   (ram_re),
    .rd_addr (sweep_addr),
    .rd_data (stg_rdata)
  );

  // Committed channel snapshot.
  mrirc_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CHANNELS)
  ) u_snap_ram (
    .clk     (clk),
    .wr_en   (snap_we),
    .wr_addr (sweep_addr),
    .wr_data (snap_wdata),
    .rd_en   (ram_re),
    .rd_addr (sweep_addr),
    .rd_data (snap_rdata)
  );

  // A failed reply never reports updated channels.
  `MRIRC_ASSERT_IMP(a_upd_only_good,
    out_vld_r && (out_data_r[1:0] != mrirc_pkg::STS_GOOD),
    out_data_r[23:21] == 3'd0, "channels updated on a failed reply")
  // A good reply always leaves the device online.
  `MRIRC_ASSERT_IMP(a_good_online,
    out_vld_r && (out_data_r[1:0] == mrirc_pkg::STS_GOOD),
    out_data_r[2], "good reply reported offline")
  // The sweep never runs past the effective channel count.
  `MRIRC_ASSERT_IMP(a_sweep_range, state_r != mrirc_pkg::ST_IDLE,
    (idx_r < eff) && (upd_r <= eff), "sweep index beyond channel count")
  // A close leaves an empty reply window behind.
  `MRIRC_ASSERT_NXT(a_close_clears, in_acc && (in_tuser == mrirc_pkg::ACT_CLOSE),
    (bpos_r == '0) && (crc_r == mrirc_pkg::CRC_INIT), "reply window not cleared on close")

endmodule

`default_nettype wire
